// ===== sv/mfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared constants for the MSP v1 frame receiver: payload buffer size, field widths
// and the header symbols. Used by the top level and the channel interfaces.
// Has no dependencies.
package mfr_pkg;

    // Payload buffer depth, 1 to 64 bytes.
    localparam int MAX_PAYLOAD = 64;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic [LEN_W-1:0]  MAX_LEN = LEN_W'(MAX_PAYLOAD);

    // Header symbols.
    localparam logic [BYTE_W-1:0] SYM_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] SYM_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] SYM_ARROW  = 8'h3E;

endpackage
`default_nettype wire

// ===== sv/mfr_rx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel that carries one received serial byte per beat.
// Depends on mfr_pkg for the byte width.
interface mfr_rx_if;
    logic                        valid;
    logic                        ready;
    logic [mfr_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/mfr_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel that carries one replayed payload byte of a good frame per beat.
// Depends on mfr_pkg for the field widths.
interface mfr_res_if;
    logic                        valid;
    logic                        ready;
    logic [mfr_pkg::BYTE_W-1:0]  frame_command;
    logic [mfr_pkg::LEN_W-1:0]   payload_length;
    logic [mfr_pkg::IDX_W-1:0]   byte_index;
    logic [mfr_pkg::BYTE_W-1:0]  payload_byte;
    logic                        last_of_frame;

    modport source (output valid, output frame_command, output payload_length,
                    output byte_index, output payload_byte, output last_of_frame,
                    input ready);
    modport sink   (input valid, input frame_command, input payload_length,
                    input byte_index, input payload_byte, input last_of_frame,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/mfr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mfr_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/msp_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the MSP v1 frame receiver: header parser, payload buffer and replay.
// Depends on mfr_pkg, mfr_rx_if, mfr_res_if and mfr_ram.

// The receiver takes one serial byte per beat on i_rx and looks for frames of the
// form '$' 'M' '>' size command payload checksum. While a frame is parsed, each byte
// is taken and payload bytes are written into a small RAM of
// MAX_PAYLOAD entries. A size byte above MAX_PAYLOAD, or any wrong header byte,
// sends the parser back to idle. The checksum is the XOR of size, command and
// payload; on a mismatch the frame is dropped with no result. On a match the stored
// payload is read back from the RAM and delivered on o_res, one beat per payload
// byte, each beat carrying the command, the length, the byte's index and the byte,
// with last_of_frame set on the final beat. An empty frame gives one beat with
// length, index and byte all zero. The checksum byte waits until the result register
// is free. A good frame then holds off further input while the replay issues one RAM
// read per cycle when o_res does not stall, through its single read port; the RAM
// registers the read data, and stalls on o_res hold the replay back.
// The result register decouples the two sides, so input bytes keep flowing while the
// last result of a frame still waits to be taken.
module msp_frame_receiver (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mfr_rx_if.sink     i_rx,
    mfr_res_if.source  o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DOLLAR,
        PH_M,
        PH_ARROW,
        PH_SIZE,
        PH_BODY,
        PH_REPLAY
    } t_phase;

    // Parser state.
    t_phase                            r_phase,   n_phase;
    logic [mfr_pkg::LEN_W-1:0]         r_size,    n_size;
    logic [mfr_pkg::LEN_W-1:0]         r_fill,    n_fill;
    logic [mfr_pkg::BYTE_W-1:0]        r_xor,     n_xor;
    logic [mfr_pkg::BYTE_W-1:0]        r_cmd,     n_cmd;

    // Replay state: read pointer, and a flag for data sitting in the RAM read register.
    logic [mfr_pkg::LEN_W-1:0]         r_rd_idx,  n_rd_idx;
    logic                              r_pend,    n_pend;
    logic [mfr_pkg::IDX_W-1:0]         r_pend_idx, n_pend_idx;

    // Result register.
    logic                              r_out_valid, n_out_valid;
    logic [mfr_pkg::BYTE_W-1:0]        r_out_cmd,   n_out_cmd;
    logic [mfr_pkg::LEN_W-1:0]         r_out_len,   n_out_len;
    logic [mfr_pkg::IDX_W-1:0]         r_out_idx,   n_out_idx;
    logic [mfr_pkg::BYTE_W-1:0]        r_out_byte,  n_out_byte;
    logic                              r_out_last,  n_out_last;

    logic                              rx_fire;
    logic                              out_free;
    logic                              at_cksum;
    logic                              rd_issue;
    logic                              rd_load;
    logic                              wr_en;
    logic [mfr_pkg::BYTE_W-1:0]        rd_data;
    logic [mfr_pkg::BYTE_W-1:0]        c;

    assign c        = i_rx.rx_byte;
    assign out_free = !r_out_valid || o_res.ready;

    // The byte after the last payload byte is the checksum.
    assign at_cksum = (r_phase == PH_BODY) &&
                      !((r_fill < r_size) && (r_fill < mfr_pkg::MAX_LEN));

    // Input stalls during replay, and on the checksum byte until the result register
    // can take an empty-frame result.
    assign i_rx.ready = (r_phase != PH_REPLAY) && (!at_cksum || out_free);
    assign rx_fire    = i_rx.valid && i_rx.ready;

    // Payload bytes go straight into the buffer at the fill position.
    assign wr_en = rx_fire && (r_phase == PH_BODY) && !at_cksum;

    // Replay pipeline: move read data into the result register when it is free, and
    // issue the next read when the read register will be empty.
    assign rd_load  = r_pend && out_free;
    assign rd_issue = (r_phase == PH_REPLAY) && (r_rd_idx < r_size) && (!r_pend || rd_load);

    mfr_ram #(
        .WIDTH (mfr_pkg::BYTE_W),
        .DEPTH (mfr_pkg::MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[mfr_pkg::ADDR_W-1:0]),
        .i_wr_data (c),
        .i_rd_en   (rd_issue),
        .i_rd_addr (r_rd_idx[mfr_pkg::ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_phase     = r_phase;
        n_size      = r_size;
        n_fill      = r_fill;
        n_xor       = r_xor;
        n_cmd       = r_cmd;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_out_valid = r_out_valid;
        n_out_cmd   = r_out_cmd;
        n_out_len   = r_out_len;
        n_out_idx   = r_out_idx;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        // Replay of a good frame.
        if (rd_load) begin
            n_out_valid = 1'b1;
            n_out_cmd   = r_cmd;
            n_out_len   = r_size;
            n_out_idx   = r_pend_idx;
            n_out_byte  = rd_data;
            n_out_last  = ({1'b0, r_pend_idx} + 1'b1) == r_size;
            n_pend      = 1'b0;
        end
        if (rd_issue) begin
            n_pend     = 1'b1;
            n_pend_idx = r_rd_idx[mfr_pkg::IDX_W-1:0];
            n_rd_idx   = r_rd_idx + 1'b1;
        end
        if ((r_phase == PH_REPLAY) && (r_rd_idx == r_size) && !r_pend) begin
            n_phase = PH_IDLE;
        end

        // Byte parser.
        if (rx_fire) begin
            case (r_phase)
                PH_DOLLAR: begin
                    n_phase = (c == mfr_pkg::SYM_M) ? PH_M : PH_IDLE;
                end
                PH_M: begin
                    n_phase = (c == mfr_pkg::SYM_ARROW) ? PH_ARROW : PH_IDLE;
                end
                PH_ARROW: begin
                    if (c > {1'b0, mfr_pkg::MAX_LEN}) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_size  = c[mfr_pkg::LEN_W-1:0];
                        n_fill  = '0;
                        n_xor   = c;
                        n_phase = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    n_cmd   = c;
                    n_xor   = r_xor ^ c;
                    n_phase = PH_BODY;
                end
                PH_BODY: begin
                    if (!at_cksum) begin
                        n_xor  = r_xor ^ c;
                        n_fill = r_fill + 1'b1;
                    end else if (r_xor == c) begin
                        if (r_size == '0) begin
                            // Empty frame: a single zero-length result.
                            n_out_valid = 1'b1;
                            n_out_cmd   = r_cmd;
                            n_out_len   = '0;
                            n_out_idx   = '0;
                            n_out_byte  = '0;
                            n_out_last  = 1'b1;
                            n_phase     = PH_IDLE;
                        end else begin
                            n_rd_idx = '0;
                            n_phase  = PH_REPLAY;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = (c == mfr_pkg::SYM_DOLLAR) ? PH_DOLLAR : PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_size      <= '0;
            r_fill      <= '0;
            r_xor       <= '0;
            r_cmd       <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_size      <= n_size;
            r_fill      <= n_fill;
            r_xor       <= n_xor;
            r_cmd       <= n_cmd;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_pend_idx <= n_pend_idx;
        r_out_cmd  <= n_out_cmd;
        r_out_len  <= n_out_len;
        r_out_idx  <= n_out_idx;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.frame_command  = r_out_cmd;
    assign o_res.payload_length = r_out_len;
    assign o_res.byte_index     = r_out_idx;
    assign o_res.payload_byte   = r_out_byte;
    assign o_res.last_of_frame  = r_out_last;

endmodule
`default_nettype wire
